@@ hdl/necir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and register codes of the NEC IR frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

	localparam int FRAME_BYTES = 4;
	localparam int TIME_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int OUT_BYTES   = 4;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;

	// byte counter reaches FRAME_BYTES itself
	localparam int BCNT_W      = $clog2(FRAME_BYTES + 1);
	localparam int BSEL_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	localparam logic [BCNT_W-1:0] LAST_BYTE_CNT = BCNT_W'(FRAME_BYTES);

	localparam logic [TIME_W-1:0] START_MIN_RST = 16'd1500;
	localparam logic [TIME_W-1:0] START_MAX_RST = 16'd1875;
	localparam logic [TIME_W-1:0] BIT_MAX_RST   = 16'd375;
	localparam logic [TIME_W-1:0] ONE_MIN_RST   = 16'd187;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MIN = 4'd0,
		REG_START_MAX = 4'd1,
		REG_BIT_MAX   = 4'd2,
		REG_ONE_MIN   = 4'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RECV
	} rx_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] start_min;
		logic [TIME_W-1:0] start_max;
		logic [TIME_W-1:0] bit_max;
		logic [TIME_W-1:0] one_min;
	} thresholds_t;

	typedef struct packed {
		logic                             frame_done;
		logic [OUT_BYTES-1:0][BYTE_W-1:0] frame_bytes;
		logic [BYTE_W-1:0]                repeat_count;
	} result_t;

endpackage

@@ hdl/necir_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_cfg_regs
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module necir_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [necir_pkg::CFG_DATA_W-1:0] cfg_data,
	output necir_pkg::thresholds_t           thr
);

	necir_pkg::thresholds_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.start_min <= necir_pkg::START_MIN_RST;
			thr_q.start_max <= necir_pkg::START_MAX_RST;
			thr_q.bit_max   <= necir_pkg::BIT_MAX_RST;
			thr_q.one_min   <= necir_pkg::ONE_MIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				necir_pkg::REG_START_MIN: thr_q.start_min <= cfg_data;
				necir_pkg::REG_START_MAX: thr_q.start_max <= cfg_data;
				necir_pkg::REG_BIT_MAX:   thr_q.bit_max   <= cfg_data;
				necir_pkg::REG_ONE_MIN:   thr_q.one_min   <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign thr = thr_q;

endmodule

@@ hdl/necir_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_decode
// Interval measurement and frame state; one capture handled per step.
// ----------------------------------------------------------------------------
module necir_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [necir_pkg::TIME_W-1:0]  capture_time,
	input  necir_pkg::thresholds_t        thr,
	output necir_pkg::result_t            result
);

	localparam int TIME_W = necir_pkg::TIME_W;
	localparam int BYTE_W = necir_pkg::BYTE_W;
	localparam int BCNT_W = necir_pkg::BCNT_W;
	localparam int BSEL_W = necir_pkg::BSEL_W;
	localparam int FB     = necir_pkg::FRAME_BYTES;

	necir_pkg::rx_state_t state_q, state_d;
	logic [TIME_W-1:0]    last_q;
	logic [BYTE_W-1:0]    shift_q, shift_d;
	logic [2:0]           bit_q, bit_d;
	logic [BCNT_W-1:0]    byte_q, byte_d;
	logic [BYTE_W-1:0]    repeats_q, repeats_d;
	logic [BYTE_W-1:0]    store_q [FB];
	logic [BYTE_W-1:0]    store_d [FB];
	logic [TIME_W-1:0]    period;
	logic [BYTE_W-1:0]    shift_bit;
	logic                 done;

	// modulo-2^16 interval
	assign period = capture_time - last_q;

	always_comb begin
		state_d   = state_q;
		shift_d   = shift_q;
		bit_d     = bit_q;
		byte_d    = byte_q;
		repeats_d = repeats_q;
		store_d   = store_q;
		done      = 1'b0;
		shift_bit = shift_q;
		case (state_q)
			necir_pkg::ST_IDLE: begin
				if (period < thr.start_max) begin
					if (period > thr.start_min) begin
						shift_d   = '0;
						bit_d     = '0;
						byte_d    = '0;
						repeats_d = '0;
						state_d   = necir_pkg::ST_RECV;
					end else begin
						repeats_d = repeats_q + 1'b1;
					end
				end
			end
			necir_pkg::ST_RECV: begin
				if (period < thr.bit_max) begin
					if (period > thr.one_min)
						shift_bit = shift_q | (BYTE_W'(1) << bit_q);
					bit_d = bit_q + 1'b1;
					if (bit_q == 3'd7) begin
						store_d[byte_q[BSEL_W-1:0]] = shift_bit;
						shift_d = '0;
						byte_d  = byte_q + 1'b1;
						if (byte_d == necir_pkg::LAST_BYTE_CNT) begin
							done    = 1'b1;
							state_d = necir_pkg::ST_IDLE;
						end
					end else begin
						shift_d = shift_bit;
					end
				end
			end
			default: state_d = necir_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= necir_pkg::ST_IDLE;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			shift_q   <= '0;
			bit_q     <= '0;
			byte_q    <= '0;
			repeats_q <= '0;
			for (int i = 0; i < FB; i++)
				store_q[i] <= '0;
		end else if (step) begin
			last_q    <= capture_time;
			shift_q   <= shift_d;
			bit_q     <= bit_d;
			byte_q    <= byte_d;
			repeats_q <= repeats_d;
			store_q   <= store_d;
		end
	end

	// result reflects the state after this capture
	assign result.frame_done   = done;
	assign result.repeat_count = repeats_d;

	for (genvar k = 0; k < necir_pkg::OUT_BYTES; k++) begin : g_out
		if (k < FB) begin : g_have
			assign result.frame_bytes[k] = store_d[k];
		end else begin : g_none
			assign result.frame_bytes[k] = '0;
		end
	end

endmodule

@@ hdl/nec_ir_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder working on falling-edge capture timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one capture timestamp per request (s_tdata[15:0]).
//   m_* returns exactly one result per capture: m_tlast is frame_done,
//   m_tdata holds the four frame bytes and the repeat counter.
//   cfg_* writes the four thresholds (index 0..3); other indexes are
//   dropped. cfg_ready is always high; write only while no capture is in
//   flight.
// Timing:
//   A capture is held in the input register, then the decode step
//   (one subtract, a few compares, state update) loads the result register,
//   which drives m_tvalid. One capture per cycle is sustained while m_tready
//   stays high; the decode step itself is combinational.
// Reset:
//   arst_n clears all frame state, empties both registers and restores the
//   default thresholds.
// Stall:
//   With m_tready low the result holds; one more capture is taken into the
//   input register, after which s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // [15:0] capture_time
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] byte_zero, [15:8] byte_one, [23:16] byte_two,
	// [31:24] byte_three, [39:32] repeat_count
	output logic [39:0]                      m_tdata,
	output logic                             m_tlast,  // frame_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [necir_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                         valid_s1;
	logic [necir_pkg::TIME_W-1:0] capture_s1;
	logic                         valid_s2;
	necir_pkg::result_t           result_s2;
	necir_pkg::result_t           result;
	necir_pkg::thresholds_t       thr;
	logic                         s2_free;
	logic                         step;

	assign s2_free  = !valid_s2 || m_tready;
	assign step     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign cfg_ready = 1'b1;

	necir_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	necir_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.capture_time (capture_s1),
		.thr          (thr),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			capture_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = result_s2.frame_done;
	assign m_tdata  = {result_s2.repeat_count,
	                   result_s2.frame_bytes[3],
	                   result_s2.frame_bytes[2],
	                   result_s2.frame_bytes[1],
	                   result_s2.frame_bytes[0]};

endmodule
